### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### src/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg
// Types, constants and small helpers for the Mercator to grid converter.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int IN_W  = 28;
    localparam int Q_W   = 32;
    localparam int SUM_W = 64;

    localparam logic signed [33:0] CENTRE_X = 34'sd530901007;
    localparam logic signed [33:0] CENTRE_Y = 34'sd335720258;
    localparam logic signed [39:0] SCALE_A  = 40'sd61;
    localparam logic signed [39:0] SCALE_B  = 40'sd36;
    localparam logic signed [39:0] Q30_ONE_W = 40'sd1073741824;
    localparam logic signed [31:0] Q30_ONE  = 32'sd1073741824;
    localparam logic signed [63:0] Q30_HALF = 64'sd536870912;

    localparam int N_EAST  = 12;
    localparam int N_NORTH = 11;

    // east monomials: 1, b, a, ab, ab2, ab3, ab4, a2b, a2b2, a3, a3b, a3b2
    localparam logic signed [31:0] EAST_COEF [N_EAST] = '{
        32'sd40000147, -32'sd1707, 32'sd37052338, 32'sd5332692, 32'sd202568,
        -32'sd24127, -32'sd4177, -32'sd1121, 32'sd1484, -32'sd23768,
        32'sd8289, 32'sd4121
    };
    // north monomials: 1, a, a2, b, a2b, b2, ab2, a2b2, b3, a2b3, b4
    localparam logic signed [31:0] NORTH_COEF [N_NORTH] = '{
        32'sd64999833, -32'sd1390, 32'sd1578238, -32'sd62649642, 32'sd122067,
        -32'sd4489811, 32'sd1001, -32'sd21721, -32'sd108827, -32'sd4959,
        32'sd10747
    };

    localparam logic signed [63:0] RND_Q16  = 64'sd819200;
    localparam logic signed [63:0] E_LIMIT  = 64'sd700000 * 64'sd65536 * 64'sd1638400;
    localparam logic signed [63:0] N_LIMIT  = 64'sd1300000 * 64'sd65536 * 64'sd1638400;
    // folds both half-up roundings ahead of a shift by 32 and a divide by 25
    localparam logic signed [63:0] RND_ALL  = 64'sd819200 * 64'sd65537;
    localparam int U_W = 25;
    localparam int D_W = 17;
    localparam logic [25:0] RECIP_250 = 26'd34359738;
    localparam int RECIP_SH = 33;

    typedef struct packed {
        logic             bad;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
        logic signed [31:0] a3;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        logic signed [31:0] b3;
        logic signed [31:0] b4;
    } pow_t;

    typedef struct packed {
        logic             bad;
        logic signed [63:0] e_sum;
        logic signed [63:0] n_sum;
    } poly_t;

    typedef struct packed {
        logic        valid_res;
        logic [6:0]  major_letter;
        logic [6:0]  minor_letter;
        logic [13:0] easting_digits;
        logic [13:0] northing_digits;
    } res_t;

    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] u,
                                                  input logic signed [31:0] v);
        logic signed [63:0] p;
        p = 64'(u) * 64'(v) + Q30_HALF;
        return p[61:30];
    endfunction

    function automatic logic [1:0] div5(input logic [3:0] v);
        logic [1:0] q;
        if (v >= 4'd10)
            q = 2'd2;
        else if (v >= 4'd5)
            q = 2'd1;
        else
            q = 2'd0;
        return q;
    endfunction

    function automatic logic [2:0] mod5(input logic [3:0] v);
        logic [3:0] r;
        r = v - 4'(div5(v)) * 4'd5;
        return r[2:0];
    endfunction

    function automatic logic [6:0] major_char(input logic [2:0] idx);
        logic [6:0] c;
        case (idx)
            3'd0:    c = 7'h53;
            3'd1:    c = 7'h4E;
            3'd2:    c = 7'h48;
            3'd3:    c = 7'h54;
            3'd4:    c = 7'h4F;
            3'd5:    c = 7'h4A;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] minor_char(input logic [4:0] idx);
        logic [6:0] c;
        case (idx)
            5'd0:    c = 7'h56;
            5'd1:    c = 7'h51;
            5'd2:    c = 7'h4C;
            5'd3:    c = 7'h46;
            5'd4:    c = 7'h41;
            5'd5:    c = 7'h57;
            5'd6:    c = 7'h52;
            5'd7:    c = 7'h4D;
            5'd8:    c = 7'h47;
            5'd9:    c = 7'h42;
            5'd10:   c = 7'h58;
            5'd11:   c = 7'h53;
            5'd12:   c = 7'h4E;
            5'd13:   c = 7'h48;
            5'd14:   c = 7'h43;
            5'd15:   c = 7'h59;
            5'd16:   c = 7'h54;
            5'd17:   c = 7'h4F;
            5'd18:   c = 7'h4A;
            5'd19:   c = 7'h44;
            5'd20:   c = 7'h5A;
            5'd21:   c = 7'h55;
            5'd22:   c = 7'h50;
            5'd23:   c = 7'h4B;
            5'd24:   c = 7'h45;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

### src/mercator_to_grid_reference.sv
// ----------------------------------------------------------------------------
// mercator_to_grid_reference
// Web-Mercator position to national grid square letters and digits.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one transaction carries a Mercator pair
//   (x_coord, y_coord). Master channel m_*: one transaction per input with
//   valid_res, two square letters (ASCII) and the four-digit easting and
//   northing in 10 m units; all fields but valid_res are zero when invalid.
//   12 register stages: 3 of power building, 4 of polynomial evaluation,
//   5 of rounding and digit split. Throughput is one transaction per
//   cycle while m_tready is high; each stage advances on its own, so
//   bubbles close up while the output waits.
//   Reset clears all stage valid bits; the pipeline is empty after reset.
//   When m_tready is low the output holds and earlier stages keep filling
//   until full, then s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module mercator_to_grid_reference
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // x_coord[27:0], y_coord[55:28]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // valid_res, major_letter, minor_letter,
                                   // easting_digits, northing_digits, pad
);

    logic           norm_valid;
    logic           norm_ready;
    mtg_pkg::pow_t  norm_data;
    logic           poly_valid;
    logic           poly_ready;
    mtg_pkg::poly_t poly_data;
    mtg_pkg::res_t  res;

    mtg_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x_coord   (s_tdata[27:0]),
        .y_coord   (s_tdata[55:28]),
        .out_valid (norm_valid),
        .out_ready (norm_ready),
        .out_data  (norm_data)
    );

    mtg_poly u_poly
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (norm_valid),
        .in_ready  (norm_ready),
        .in_data   (norm_data),
        .out_valid (poly_valid),
        .out_ready (poly_ready),
        .out_data  (poly_data)
    );

    mtg_grid u_grid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (poly_valid),
        .in_ready  (poly_ready),
        .in_data   (poly_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {5'b0, res.northing_digits, res.easting_digits,
                      res.minor_letter, res.major_letter, res.valid_res};

endmodule

### src/mtg_norm.sv
// ----------------------------------------------------------------------------
// mtg_norm
// Normalizes the Mercator pair and builds the Q30 powers (3 stages).
// ----------------------------------------------------------------------------
module mtg_norm
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mtg_pkg::IN_W-1:0]      x_coord,
    input  logic [mtg_pkg::IN_W-1:0]      y_coord,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mtg_pkg::pow_t                 out_data
);

    localparam int NS = 3;

    logic [NS-1:0]      v_reg;
    logic [NS-1:0]      en;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [39:0] alpha_w;
    logic signed [39:0] beta_w;
    logic               bad_w;
    mtg_pkg::pow_t      s1_reg;
    mtg_pkg::pow_t      s2_reg;
    mtg_pkg::pow_t      s3_reg;
    mtg_pkg::pow_t      s1_next;
    mtg_pkg::pow_t      s2_next;
    mtg_pkg::pow_t      s3_next;

    always_comb
    begin
        en[NS-1] = ~v_reg[NS-1] | out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = ~v_reg[k] | en[k+1];
        end
    end

    assign dx      = $signed({4'b0, x_coord, 2'b00}) - mtg_pkg::CENTRE_X;
    assign dy      = $signed({4'b0, y_coord, 2'b00}) - mtg_pkg::CENTRE_Y;
    assign alpha_w = 40'(dx) * mtg_pkg::SCALE_A;
    assign beta_w  = 40'(dy) * mtg_pkg::SCALE_B;
    assign bad_w   = (alpha_w < -mtg_pkg::Q30_ONE_W) || (alpha_w > mtg_pkg::Q30_ONE_W) ||
                     (beta_w < -mtg_pkg::Q30_ONE_W) || (beta_w > mtg_pkg::Q30_ONE_W);

    always_comb
    begin
        s1_next     = '0;
        s1_next.bad = bad_w;
        s1_next.a1  = alpha_w[31:0];
        s1_next.b1  = beta_w[31:0];
        s2_next     = s1_reg;
        s2_next.a2  = mtg_pkg::mul_q30(s1_reg.a1, s1_reg.a1);
        s2_next.b2  = mtg_pkg::mul_q30(s1_reg.b1, s1_reg.b1);
        s3_next     = s2_reg;
        s3_next.a3  = mtg_pkg::mul_q30(s2_reg.a2, s2_reg.a1);
        s3_next.b3  = mtg_pkg::mul_q30(s2_reg.b2, s2_reg.b1);
        s3_next.b4  = mtg_pkg::mul_q30(s2_reg.b2, s2_reg.b2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            s1_reg <= s1_next;
        if (en[1])
            s2_reg <= s2_next;
        if (en[2])
            s3_reg <= s3_next;
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = s3_reg;

endmodule

### src/mtg_poly.sv
// ----------------------------------------------------------------------------
// mtg_poly
// Monomials, coefficient products and sum tree for easting and northing.
// ----------------------------------------------------------------------------
module mtg_poly
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mtg_pkg::pow_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output mtg_pkg::poly_t out_data
);

    localparam int NS = 4;
    localparam int NG = 3;

    logic [NS-1:0]      v_reg;
    logic [NS-1:0]      en;
    logic               bad_reg [NS];
    logic signed [31:0] em_reg [mtg_pkg::N_EAST];
    logic signed [31:0] nm_reg [mtg_pkg::N_NORTH];
    logic signed [63:0] ep_reg [mtg_pkg::N_EAST];
    logic signed [63:0] np_reg [mtg_pkg::N_NORTH];
    logic signed [63:0] eg_reg [NG];
    logic signed [63:0] ng_reg [NG];
    logic signed [63:0] esum_reg;
    logic signed [63:0] nsum_reg;
    logic signed [31:0] ab;
    logic signed [31:0] ab2;
    logic signed [31:0] a2b;
    logic signed [31:0] a2b2;

    always_comb
    begin
        en[NS-1] = ~v_reg[NS-1] | out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = ~v_reg[k] | en[k+1];
        end
    end

    assign ab   = mtg_pkg::mul_q30(in_data.a1, in_data.b1);
    assign ab2  = mtg_pkg::mul_q30(in_data.a1, in_data.b2);
    assign a2b  = mtg_pkg::mul_q30(in_data.a2, in_data.b1);
    assign a2b2 = mtg_pkg::mul_q30(in_data.a2, in_data.b2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            bad_reg[0] <= in_data.bad;
            em_reg[0]  <= mtg_pkg::Q30_ONE;
            em_reg[1]  <= in_data.b1;
            em_reg[2]  <= in_data.a1;
            em_reg[3]  <= ab;
            em_reg[4]  <= ab2;
            em_reg[5]  <= mtg_pkg::mul_q30(in_data.a1, in_data.b3);
            em_reg[6]  <= mtg_pkg::mul_q30(in_data.a1, in_data.b4);
            em_reg[7]  <= a2b;
            em_reg[8]  <= a2b2;
            em_reg[9]  <= in_data.a3;
            em_reg[10] <= mtg_pkg::mul_q30(in_data.a3, in_data.b1);
            em_reg[11] <= mtg_pkg::mul_q30(in_data.a3, in_data.b2);
            nm_reg[0]  <= mtg_pkg::Q30_ONE;
            nm_reg[1]  <= in_data.a1;
            nm_reg[2]  <= in_data.a2;
            nm_reg[3]  <= in_data.b1;
            nm_reg[4]  <= a2b;
            nm_reg[5]  <= in_data.b2;
            nm_reg[6]  <= ab2;
            nm_reg[7]  <= a2b2;
            nm_reg[8]  <= in_data.b3;
            nm_reg[9]  <= mtg_pkg::mul_q30(in_data.a2, in_data.b3);
            nm_reg[10] <= in_data.b4;
        end
        if (en[1])
        begin
            bad_reg[1] <= bad_reg[0];
            for (int k = 0; k < mtg_pkg::N_EAST; k++)
            begin
                ep_reg[k] <= 64'(mtg_pkg::EAST_COEF[k]) * 64'(em_reg[k]);
            end
            for (int k = 0; k < mtg_pkg::N_NORTH; k++)
            begin
                np_reg[k] <= 64'(mtg_pkg::NORTH_COEF[k]) * 64'(nm_reg[k]);
            end
        end
        if (en[2])
        begin
            bad_reg[2] <= bad_reg[1];
            for (int g = 0; g < NG; g++)
            begin
                eg_reg[g] <= ep_reg[4*g] + ep_reg[4*g+1] + ep_reg[4*g+2] + ep_reg[4*g+3];
            end
            ng_reg[0] <= np_reg[0] + np_reg[1] + np_reg[2] + np_reg[3];
            ng_reg[1] <= np_reg[4] + np_reg[5] + np_reg[6] + np_reg[7];
            ng_reg[2] <= np_reg[8] + np_reg[9] + np_reg[10];
        end
        if (en[3])
        begin
            bad_reg[3] <= bad_reg[2];
            esum_reg   <= eg_reg[0] + eg_reg[1] + eg_reg[2];
            nsum_reg   <= ng_reg[0] + ng_reg[1] + ng_reg[2];
        end
    end

    assign in_ready        = en[0];
    assign out_valid       = v_reg[NS-1];
    assign out_data.bad    = bad_reg[NS-1];
    assign out_data.e_sum  = esum_reg;
    assign out_data.n_sum  = nsum_reg;

endmodule

### src/mtg_grid.sv
// ----------------------------------------------------------------------------
// mtg_grid
// Range check, rounding, divide by ten, digit split and square letter lookup.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtg_grid
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mtg_pkg::poly_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output mtg_pkg::res_t  out_data
);

    localparam int NS = 5;

    logic [NS-1:0]                v_reg;
    logic [NS-1:0]                en;
    logic                         bad_reg [NS-1];
    logic signed [63:0]           et;
    logic signed [63:0]           nt;
    logic signed [63:0]           eu;
    logic signed [63:0]           nu;
    logic [mtg_pkg::U_W-1:0]      eu_reg;
    logic [mtg_pkg::U_W-1:0]      nu_reg;
    logic [mtg_pkg::U_W-1:0]      eu2_reg;
    logic [mtg_pkg::U_W-1:0]      nu2_reg;
    logic [50:0]                  eprod;
    logic [50:0]                  nprod;
    logic [mtg_pkg::D_W:0]        eq_reg;
    logic [mtg_pkg::D_W:0]        nq_reg;
    logic [25:0]                  er;
    logic [25:0]                  nr;
    logic [mtg_pkg::D_W-1:0]      e_reg;
    logic [mtg_pkg::D_W-1:0]      n_reg;
    logic [3:0]                   e0;
    logic [3:0]                   n0;
    logic [3:0]                   e0_reg;
    logic [3:0]                   n0_reg;
    logic [13:0]                  ed_reg;
    logic [13:0]                  nd_reg;
    logic [2:0]                   maj_idx;
    logic [4:0]                   min_idx;
    mtg_pkg::res_t                res_reg;

    always_comb
    begin
        en[NS-1] = ~v_reg[NS-1] | out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = ~v_reg[k] | en[k+1];
        end
    end

    assign et = in_data.e_sum + mtg_pkg::RND_Q16;
    assign nt = in_data.n_sum + mtg_pkg::RND_Q16;
    assign eu = (in_data.e_sum + mtg_pkg::RND_ALL) >>> 32;
    assign nu = (in_data.n_sum + mtg_pkg::RND_ALL) >>> 32;

    assign eprod = 51'(eu_reg) * 51'(mtg_pkg::RECIP_250);
    assign nprod = 51'(nu_reg) * 51'(mtg_pkg::RECIP_250);

    assign er = 26'(eu2_reg) - 26'(eq_reg) * 26'd250;
    assign nr = 26'(nu2_reg) - 26'(nq_reg) * 26'd250;

    // values that round up onto the outer grid edge reach square 7 (easting) or 13 (northing)
    always_comb
    begin
        e0 = '0;
        n0 = '0;
        for (int k = 1; k <= 13; k++)
        begin
            if (e_reg >= mtg_pkg::D_W'(k * 10000))
                e0 = 4'(k);
            if (n_reg >= mtg_pkg::D_W'(k * 10000))
                n0 = 4'(k);
        end
    end

    assign maj_idx = 3'(3 * mtg_pkg::div5(e0_reg)) + 3'(mtg_pkg::div5(n0_reg));
    assign min_idx = 5'(5 * mtg_pkg::mod5(e0_reg)) + 5'(mtg_pkg::mod5(n0_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            bad_reg[0] <= in_data.bad || (et < 0) || (et >= mtg_pkg::E_LIMIT) ||
                          (nt < 0) || (nt >= mtg_pkg::N_LIMIT);
            eu_reg     <= eu[mtg_pkg::U_W-1:0];
            nu_reg     <= nu[mtg_pkg::U_W-1:0];
        end
        if (en[1])
        begin
            bad_reg[1] <= bad_reg[0];
            eu2_reg    <= eu_reg;
            nu2_reg    <= nu_reg;
            eq_reg     <= eprod[50:mtg_pkg::RECIP_SH];
            nq_reg     <= nprod[50:mtg_pkg::RECIP_SH];
        end
        if (en[2])
        begin
            bad_reg[2] <= bad_reg[1];
            e_reg      <= (er >= 26'd250) ? mtg_pkg::D_W'(eq_reg + 1'b1)
                                          : eq_reg[mtg_pkg::D_W-1:0];
            n_reg      <= (nr >= 26'd250) ? mtg_pkg::D_W'(nq_reg + 1'b1)
                                          : nq_reg[mtg_pkg::D_W-1:0];
        end
        if (en[3])
        begin
            bad_reg[3] <= bad_reg[2];
            e0_reg     <= e0;
            n0_reg     <= n0;
            ed_reg     <= 14'(e_reg - mtg_pkg::D_W'(e0) * mtg_pkg::D_W'(10000));
            nd_reg     <= 14'(n_reg - mtg_pkg::D_W'(n0) * mtg_pkg::D_W'(10000));
        end
        if (en[4])
        begin
            if (bad_reg[3])
            begin
                res_reg <= '0;
            end
            else
            begin
                res_reg.valid_res       <= 1'b1;
                res_reg.major_letter    <= mtg_pkg::major_char(maj_idx);
                res_reg.minor_letter    <= mtg_pkg::minor_char(min_idx);
                res_reg.easting_digits  <= ed_reg;
                res_reg.northing_digits <= nd_reg;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = res_reg;

    `ASSERT_CLK(a_digits_range, clk, rst_n,
        out_valid |-> (res_reg.easting_digits < 14'd10000 &&
                       res_reg.northing_digits < 14'd10000))
    `ASSERT_CLK(a_invalid_zero, clk, rst_n,
        (out_valid && !res_reg.valid_res) |-> (res_reg.major_letter == 7'd0 &&
         res_reg.minor_letter == 7'd0 && res_reg.easting_digits == 14'd0))
    `ASSERT_NEVER(a_valid_no_letter, clk, rst_n,
        out_valid && res_reg.valid_res &&
        (res_reg.major_letter == 7'd0 || res_reg.minor_letter == 7'd0))

endmodule

### dv/mtg_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtg_checker
// Watches both stream channels of the grid reference converter, computes the
// expected grid reference for every accepted coordinate pair and compares it
// field by field with each result transaction, oldest first.
// ----------------------------------------------------------------------------
module mtg_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        bit       ok;
        bit [6:0] major;
        bit [6:0] minor;
        bit [13:0] east_d;
        bit [13:0] north_d;
    } grid_ref_t;

    grid_ref_t ref_queue[$];

    function automatic longint qmul(longint u, longint v);
        return (u * v + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function automatic longint fdiv(longint v, longint d);
        longint q;
        q = v / d;
        if ((v % d) != 0 && v < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic grid_ref_t grid_of(bit [27:0] xc, bit [27:0] yc);
        grid_ref_t r;
        longint one, al, be, a2, a3, b2, b3, b4, es, ns, eq, nq, e, n, e0, n0;
        string majors, minors;
        majors = "SNHTOJ";
        minors = "VQLFAWRMGBXSNHCYTOJDZUPKE";
        r = '{0, 0, 0, 0, 0};
        one = longint'(1) <<< 30;
        al = 61 * (longint'(xc) * 4 - 530901007);
        be = 36 * (longint'(yc) * 4 - 335720258);
        if (al < -one || al > one || be < -one || be > one)
            return r;
        a2 = qmul(al, al);
        a3 = qmul(a2, al);
        b2 = qmul(be, be);
        b3 = qmul(b2, be);
        b4 = qmul(b2, b2);
        es = 40000147 * one - 1707 * be + 37052338 * al + 5332692 * qmul(al, be)
           + 202568 * qmul(al, b2) - 24127 * qmul(al, b3) - 4177 * qmul(al, b4)
           - 1121 * qmul(a2, be) + 1484 * qmul(a2, b2) - 23768 * a3
           + 8289 * qmul(a3, be) + 4121 * qmul(a3, b2);
        ns = 64999833 * one - 1390 * al + 1578238 * a2 - 62649642 * be
           + 122067 * qmul(a2, be) - 4489811 * b2 + 1001 * qmul(al, b2)
           - 21721 * qmul(a2, b2) - 108827 * b3 - 4959 * qmul(a2, b3)
           + 10747 * b4;
        eq = fdiv(es + 819200, 1638400);
        nq = fdiv(ns + 819200, 1638400);
        if (eq < 0 || eq >= longint'(700000) * 65536 || nq < 0
            || nq >= longint'(1300000) * 65536)
            return r;
        e = ((eq + 32768) >>> 16) / 10;
        n = ((nq + 32768) >>> 16) / 10;
        e0 = e / 10000;
        n0 = n / 10000;
        r.ok = 1;
        r.major = majors[(3 * (e0 / 5) + (n0 / 5)) % 6];
        r.minor = minors[(5 * (e0 % 5) + (n0 % 5)) % 25];
        r.east_d = e % 10000;
        r.north_d = n % 10000;
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, field, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending = ref_queue.size();

    always @(posedge clk)
    begin
        grid_ref_t w;
        if (rst_n && s_tvalid && s_tready)
            ref_queue.push_back(grid_of(s_tdata[27:0], s_tdata[55:28]));
        if (rst_n && m_tvalid && m_tready)
        begin
            if (ref_queue.size() == 0)
                report_mismatch("unexpected transaction", 1, 0);
            else
            begin
                w = ref_queue.pop_front();
                if (m_tdata[0] != w.ok)
                    report_mismatch("valid_res", m_tdata[0], w.ok);
                if (m_tdata[7:1] != w.major)
                    report_mismatch("major_letter", m_tdata[7:1], w.major);
                if (m_tdata[14:8] != w.minor)
                    report_mismatch("minor_letter", m_tdata[14:8], w.minor);
                if (m_tdata[28:15] != w.east_d)
                    report_mismatch("easting_digits", m_tdata[28:15], w.east_d);
                if (m_tdata[42:29] != w.north_d)
                    report_mismatch("northing_digits", m_tdata[42:29], w.north_d);
            end
        end
    end
endmodule

### dv/tb_mercator_to_grid_reference.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mercator_to_grid_reference
// Drives coordinate pairs into the converter with random gaps and output
// stalls, including one long output hold-off, and reports the verdict from
// the checker's mismatch count or from an idle watchdog.
// ----------------------------------------------------------------------------
module tb_mercator_to_grid_reference;
    localparam int X_LO = 128324670;
    localparam int X_HI = 137125832;
    localparam int Y_LO = 76473524;
    localparam int Y_HI = 91386604;
    localparam int N_RANDOM = 430;
    localparam int IDLE_LIMIT = 3000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    int          fail_count;
    int          pending;
    bit          hold_off = 0;
    int          idle_cycles = 0;

    always #4 clk = ~clk;

    mercator_to_grid_reference dut (.*);
    mtg_checker checker_i (.*);

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // s_tvalid stays high between back-to-back transactions
    task automatic send_pair(bit [27:0] xc, bit [27:0] yc);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {yc, xc};
        @(posedge clk iff s_tready);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int g;
        @(negedge clk);
        while (1)
        begin
            if (hold_off)
                m_tready <= 0;
            else if ($urandom_range(0, 3) == 0)
            begin
                g = gap_len() + 1;
                m_tready <= 0;
                repeat (g - 1) @(negedge clk);
            end
            else
                m_tready <= 1;
            @(negedge clk);
        end
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        send_pair(0, 0);
        send_pair(28'hFFFFFFF, 28'hFFFFFFF);
        send_pair(0, 28'hFFFFFFF);
        send_pair(28'hFFFFFFF, 0);
        send_pair(X_LO, Y_LO);
        send_pair(X_HI, Y_HI);
        send_pair(X_LO - 1, Y_LO);
        send_pair(X_HI + 1, Y_HI);
        send_pair(X_LO, Y_LO - 1);
        send_pair(X_HI, Y_HI + 1);
        send_pair(X_LO, Y_HI);
        send_pair(X_HI, Y_LO);
        send_pair(132725251, 83930064);
        send_pair(132725251, Y_LO);
        send_pair(132725251, Y_HI);
        send_pair(X_LO, 83930064);
        send_pair(X_HI, 83930064);
        send_pair(131000000, 82000000);
        send_pair(134500000, 86000000);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 150)
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(negedge clk);
                        hold_off = 0;
                    end
                join_none
            if ($urandom_range(0, 9) < 8)
                send_pair($urandom_range(X_LO, X_HI), $urandom_range(Y_LO, Y_HI));
            else
                send_pair($urandom_range(0, 28'hFFFFFFF), $urandom_range(0, 28'hFFFFFFF));
        end
        s_tvalid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
